// ===== hw/rtl/rdmc_pkg.sv =====
`default_nettype none

package rdmc_pkg;

   localparam int unsigned TIMEOUT_WIDTH = 16;
   localparam int unsigned CODE_WIDTH    = 5;
   localparam int unsigned POWER_WIDTH   = 8;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLEEP_TIMEOUT = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IDLE_TIMEOUT  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UPDATE_CODE   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPEED_LEFT    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPEED_RIGHT   = 3'd4;

   localparam logic [TIMEOUT_WIDTH-1:0] SLEEP_TIMEOUT_RESET = 16'd5000;
   localparam logic [TIMEOUT_WIDTH-1:0] IDLE_TIMEOUT_RESET  = 16'd40000;
   localparam logic [CODE_WIDTH-1:0]    UPDATE_CODE_RESET   = 5'd0;
   localparam logic [CODE_WIDTH-1:0]    SPEED_LEFT_RESET    = 5'd1;
   localparam logic [CODE_WIDTH-1:0]    SPEED_RIGHT_RESET   = 5'd2;

   localparam logic [TIMEOUT_WIDTH-1:0] ELAPSED_MAX = '1;

   localparam logic ACTION_TICK    = 1'b0;
   localparam logic ACTION_COMMAND = 1'b1;

   localparam logic [1:0] MODE_CODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_CODE_SLEEP = 2'd1;
   localparam logic [1:0] MODE_CODE_DRIVE = 2'd2;

   localparam logic [1:0] DIR_FREE    = 2'd0;
   localparam logic [1:0] DIR_FORWARD = 2'd1;
   localparam logic [1:0] DIR_REVERSE = 2'd2;

   typedef enum logic [2:0] {
      STATE_IDLE  = 3'b001,
      STATE_SLEEP = 3'b010,
      STATE_DRIVE = 3'b100
   } mode_type;

   typedef struct packed {
      logic                          action;
      logic [CODE_WIDTH-1:0]         command_code;
      logic signed [POWER_WIDTH-1:0] command_value;
   } item_type;

   typedef struct packed {
      logic [TIMEOUT_WIDTH-1:0] sleep_timeout_ms;
      logic [TIMEOUT_WIDTH-1:0] idle_timeout_ms;
      logic [CODE_WIDTH-1:0]    update_code;
      logic [CODE_WIDTH-1:0]    speed_left_code;
      logic [CODE_WIDTH-1:0]    speed_right_code;
   } cfg_type;

   typedef struct packed {
      logic [1:0]             mode;
      logic [1:0]             left_direction;
      logic [1:0]             right_direction;
      logic [POWER_WIDTH-1:0] left_duty;
      logic [POWER_WIDTH-1:0] right_duty;
      logic                   report_request;
   } result_type;

   function automatic logic [1:0] mode_code(input mode_type m);
      logic [1:0] code;
      unique case (m)
         STATE_IDLE:  code = MODE_CODE_IDLE;
         STATE_SLEEP: code = MODE_CODE_SLEEP;
         STATE_DRIVE: code = MODE_CODE_DRIVE;
         default:     code = MODE_CODE_IDLE;
      endcase
      return code;
   endfunction

   function automatic logic [1:0] direction_of(input logic signed [POWER_WIDTH-1:0] p);
      logic [1:0] dir;
      if (p == '0) begin
         dir = DIR_FREE;
      end else if (p[POWER_WIDTH-1]) begin
         dir = DIR_REVERSE;
      end else begin
         dir = DIR_FORWARD;
      end
      return dir;
   endfunction

   // twice the magnitude; the most negative power saturates to all ones
   function automatic logic [POWER_WIDTH-1:0] duty_of(input logic signed [POWER_WIDTH-1:0] p);
      logic [POWER_WIDTH-1:0] mag;
      logic [POWER_WIDTH-1:0] duty;
      mag = p[POWER_WIDTH-1] ? (~p + 1'b1) : p;
      if (mag[POWER_WIDTH-1]) begin
         duty = '1;
      end else begin
         duty = {mag[POWER_WIDTH-2:0], 1'b0};
      end
      return duty;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rdmc_if.sv =====
`default_nettype none

interface rdmc_req_if
   import rdmc_pkg::*;
();
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [CODE_WIDTH-1:0]         command_code;
   logic signed [POWER_WIDTH-1:0] command_value;

   modport source (output valid, output action, output command_code,
                   output command_value, input ready);
   modport sink   (input valid, input action, input command_code,
                   input command_value, output ready);
endinterface

interface rdmc_rsp_if
   import rdmc_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [1:0]             mode;
   logic [1:0]             left_direction;
   logic [1:0]             right_direction;
   logic [POWER_WIDTH-1:0] left_duty;
   logic [POWER_WIDTH-1:0] right_duty;
   logic                   report_request;

   modport source (output valid, output mode, output left_direction,
                   output right_direction, output left_duty, output right_duty,
                   output report_request, input ready);
   modport sink   (input valid, input mode, input left_direction,
                   input right_direction, input left_duty, input right_duty,
                   input report_request, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rdmc_csr.sv =====
`default_nettype none

module rdmc_csr
   import rdmc_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output cfg_type                         cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SLEEP_TIMEOUT: cfg_in.sleep_timeout_ms = csr_wdata[TIMEOUT_WIDTH-1:0];
            CSR_IDLE_TIMEOUT:  cfg_in.idle_timeout_ms  = csr_wdata[TIMEOUT_WIDTH-1:0];
            CSR_UPDATE_CODE:   cfg_in.update_code      = csr_wdata[CODE_WIDTH-1:0];
            CSR_SPEED_LEFT:    cfg_in.speed_left_code  = csr_wdata[CODE_WIDTH-1:0];
            CSR_SPEED_RIGHT:   cfg_in.speed_right_code = csr_wdata[CODE_WIDTH-1:0];
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sleep_timeout_ms <= SLEEP_TIMEOUT_RESET;
         cfg_ff.idle_timeout_ms  <= IDLE_TIMEOUT_RESET;
         cfg_ff.update_code      <= UPDATE_CODE_RESET;
         cfg_ff.speed_left_code  <= SPEED_LEFT_RESET;
         cfg_ff.speed_right_code <= SPEED_RIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rdmc_core.sv =====
`default_nettype none

module rdmc_core
   import rdmc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     enable,
   input  wire item_type item,
   input  wire cfg_type  cfg,
   output result_type    result
);

   mode_type                      mode_ff, mode_in;
   logic signed [POWER_WIDTH-1:0] left_power_ff, left_power_in;
   logic signed [POWER_WIDTH-1:0] right_power_ff, right_power_in;
   logic signed [POWER_WIDTH-1:0] applied_left_ff, applied_left_in;
   logic signed [POWER_WIDTH-1:0] applied_right_ff, applied_right_in;
   logic [TIMEOUT_WIDTH-1:0]      elapsed_ff, elapsed_in;
   logic                          report;

   always_comb begin
      mode_in          = mode_ff;
      left_power_in    = left_power_ff;
      right_power_in   = right_power_ff;
      applied_left_in  = applied_left_ff;
      applied_right_in = applied_right_ff;
      elapsed_in       = elapsed_ff;
      report           = 1'b0;

      // update wins over speed-left, which wins over speed-right
      if (item.action == ACTION_TICK) begin
         if (elapsed_ff != ELAPSED_MAX) begin
            elapsed_in = elapsed_ff + 1'b1;
         end
      end else if (item.command_code == cfg.update_code) begin
         elapsed_in = '0;
         report     = 1'b1;
         if (mode_ff == STATE_SLEEP) begin
            applied_left_in  = left_power_ff;
            applied_right_in = right_power_ff;
            mode_in          = STATE_DRIVE;
         end
      end else if (item.command_code == cfg.speed_left_code) begin
         left_power_in = item.command_value;
      end else if (item.command_code == cfg.speed_right_code) begin
         right_power_in   = item.command_value;
         applied_left_in  = left_power_ff;
         applied_right_in = item.command_value;
         mode_in          = STATE_DRIVE;
      end

      // timeout check runs on the state left by the action
      if (mode_in == STATE_DRIVE) begin
         if (elapsed_in > cfg.idle_timeout_ms) begin
            applied_left_in  = '0;
            applied_right_in = '0;
            mode_in          = STATE_IDLE;
         end else if (elapsed_in > cfg.sleep_timeout_ms) begin
            applied_left_in  = '0;
            applied_right_in = '0;
            mode_in          = STATE_SLEEP;
         end
      end
   end

   always_comb begin
      result.mode            = mode_code(mode_in);
      result.left_direction  = direction_of(applied_left_in);
      result.right_direction = direction_of(applied_right_in);
      result.left_duty       = duty_of(applied_left_in);
      result.right_duty      = duty_of(applied_right_in);
      result.report_request  = report;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= STATE_IDLE;
         left_power_ff    <= '0;
         right_power_ff   <= '0;
         applied_left_ff  <= '0;
         applied_right_ff <= '0;
         elapsed_ff       <= '0;
      end else if (enable) begin
         mode_ff          <= mode_in;
         left_power_ff    <= left_power_in;
         right_power_ff   <= right_power_in;
         applied_left_ff  <= applied_left_in;
         applied_right_ff <= applied_right_in;
         elapsed_ff       <= elapsed_in;
      end
   end

   // motors are stopped whenever the block is not driving
   a_stopped_off_drive: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != STATE_DRIVE) |-> (applied_left_ff == '0 && applied_right_ff == '0))
      else $error("motors applied outside drive mode");

   a_update_clears_timer: assert property (@(posedge clock) disable iff (reset)
      (enable && item.action == ACTION_COMMAND && item.command_code == cfg.update_code)
      |=> (elapsed_ff == '0))
      else $error("update command did not clear the timer");

   a_tick_counts: assert property (@(posedge clock) disable iff (reset)
      (enable && item.action == ACTION_TICK && elapsed_ff != ELAPSED_MAX)
      |=> (elapsed_ff == $past(elapsed_ff) + 16'd1))
      else $error("tick did not advance the timer");

   a_report_only_on_update: assert property (@(posedge clock) disable iff (reset)
      report |-> (item.action == ACTION_COMMAND && item.command_code == cfg.update_code))
      else $error("report raised without an update command");

endmodule

`default_nettype wire

// ===== hw/rtl/remote_drive_mode_controller_unit.sv =====
`default_nettype none

// Remote drive mode controller.
// The req channel carries one item per millisecond tick or per received
// remote command (action, command_code, command_value). Every accepted item
// produces exactly one item on the rsp channel: the drive mode and the
// direction and duty of both motors after the item, plus a report request
// flag that is high only for an update command.
// The csr port writes the timeouts and the command codes; the user must write
// registers only while no item is in flight, as the block does not enforce it.
// An accepted item is held in the input register. When the result register
// is free or rsp is ready, the core updates the mode state and the result
// is loaded into the result register, which drives rsp. One item per cycle
// is sustained while rsp does not stall.
// When rsp stalls, the result register holds and the input register still
// takes one more item; req.ready drops only once both registers are full.
// Reset clears the pipeline valids, the mode (idle), stored powers, the
// timer and the configuration to its defaults.

module remote_drive_mode_controller_unit
   import rdmc_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   rdmc_req_if.sink                        req,
   rdmc_rsp_if.source                      rsp,
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   result_type result;
   result_type result_ff;
   logic       result_valid_ff, result_valid_in;
   logic       advance;
   logic       accept;

   rdmc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rdmc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // move the held item into the result register when that register frees up
   assign advance   = item_valid_ff && (!result_valid_ff || rsp.ready);
   assign req.ready = !item_valid_ff || advance;
   assign accept    = req.valid && req.ready;

   always_comb begin
      item_in               = item_ff;
      item_valid_in         = item_valid_ff;
      result_valid_in       = result_valid_ff;
      if (accept) begin
         item_in.action        = req.action;
         item_in.command_code  = req.command_code;
         item_in.command_value = req.command_value;
         item_valid_in         = 1'b1;
      end else if (advance) begin
         item_valid_in         = 1'b0;
      end
      if (advance) begin
         result_valid_in = 1'b1;
      end else if (rsp.ready) begin
         result_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff   <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         item_valid_ff   <= item_valid_in;
         result_valid_ff <= result_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp.valid           = result_valid_ff;
   assign rsp.mode            = result_ff.mode;
   assign rsp.left_direction  = result_ff.left_direction;
   assign rsp.right_direction = result_ff.right_direction;
   assign rsp.left_duty       = result_ff.left_duty;
   assign rsp.right_duty      = result_ff.right_duty;
   assign rsp.report_request  = result_ff.report_request;

endmodule

`default_nettype wire
